// ===== rtl/pqd_pkg.sv =====
`timescale 1ns / 1ps

package pqd_pkg;

  localparam int CFG_INDEX_WIDTH = 3;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_C0X,
    REG_C0Y,
    REG_C1X,
    REG_C1Y,
    REG_C2X,
    REG_C2Y,
    REG_C3X,
    REG_C3Y
  } cfg_reg_t;

  // nearest feature of one edge: none (degenerate), start corner, end corner, interior
  typedef enum logic [1:0] {
    EDGE_NONE,
    EDGE_NEAR,
    EDGE_FAR,
    EDGE_PERP
  } edge_kind_t;

endpackage

// ===== rtl/pqd_edge_front.sv =====
`timescale 1ns / 1ps

module pqd_edge_front #(
  parameter int W = 28
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [W-1:0]    ax,
  input  logic signed [W-1:0]    ay,
  input  logic signed [W-1:0]    bx,
  input  logic signed [W-1:0]    by,
  input  logic signed [W-1:0]    px,
  input  logic signed [W-1:0]    py,
  output logic [2*W:0]           r,
  output logic [2*W:0]           nq,
  output logic [2*W:0]           d,
  output pqd_pkg::edge_kind_t    kind,
  output logic [2*W:0]           alt,
  output logic                   pos,
  output logic                   neg
);

  localparam int DW = 2 * W + 1;
  localparam int PW = 2 * W + 2;
  localparam int H  = W + 1;
  localparam int NW = 4 * W + 2;

  logic signed [W:0]    ex, ey, fx, fy, dx, dy;
  logic signed [PW-1:0] pc1, pc2, pd1, pd2, pn1, pn2, pe1, pe2, pf1, pf2;
  logic signed [PW-1:0] cr, dot;
  logic [DW-1:0]        den, e2, f2;
  logic [DW-1:0]        crm;
  logic [W-1:0]         ch;
  logic [H-1:0]         cl;
  logic [2*W-1:0]       hh;
  logic [2*W:0]         hl;
  logic [2*H-1:0]       ll;
  logic                 pos4, neg4;
  pqd_pkg::edge_kind_t  kind4, kind_next;
  logic [DW-1:0]        alt4, den4;
  logic [NW-1:0]        n;

  always_ff @(posedge clk) begin
    if (en) begin
      ex <= {px[W-1], px} - {ax[W-1], ax};
      ey <= {py[W-1], py} - {ay[W-1], ay};
      fx <= {px[W-1], px} - {bx[W-1], bx};
      fy <= {py[W-1], py} - {by[W-1], by};
      dx <= {bx[W-1], bx} - {ax[W-1], ax};
      dy <= {by[W-1], by} - {ay[W-1], ay};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc1 <= dx * ey;
      pc2 <= dy * ex;
      pd1 <= ex * dx;
      pd2 <= ey * dy;
      pn1 <= dx * dx;
      pn2 <= dy * dy;
      pe1 <= ex * ex;
      pe2 <= ey * ey;
      pf1 <= fx * fx;
      pf2 <= fy * fy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cr  <= pc1 - pc2;
      dot <= pd1 + pd2;
      den <= pn1[DW-1:0] + pn2[DW-1:0];
      e2  <= pe1[DW-1:0] + pe2[DW-1:0];
      f2  <= pf1[DW-1:0] + pf2[DW-1:0];
    end
  end

  always_comb begin
    logic signed [PW-1:0] ncr;
    ncr = -cr;
    crm = cr[PW-1] ? ncr[DW-1:0] : cr[DW-1:0];
    cl  = crm[H-1:0];
    ch  = crm[DW-1:H];
    if (den == '0) begin
      kind_next = pqd_pkg::EDGE_NONE;
    end else if (dot[PW-1] || dot == '0) begin
      kind_next = pqd_pkg::EDGE_NEAR;
    end else if (dot >= $signed({1'b0, den})) begin
      kind_next = pqd_pkg::EDGE_FAR;
    end else begin
      kind_next = pqd_pkg::EDGE_PERP;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hh    <= ch * ch;
      hl    <= ch * cl;
      ll    <= cl * cl;
      pos4  <= !cr[PW-1] && (cr != '0);
      neg4  <= cr[PW-1];
      kind4 <= kind_next;
      alt4  <= (dot[PW-1] || dot == '0) ? e2 : f2;
      den4  <= den;
    end
  end

  assign n = (NW'(hh) << (2 * H)) + (NW'(hl) << (H + 1)) + NW'(ll);

  always_ff @(posedge clk) begin
    if (en) begin
      r    <= n[NW-1:DW];
      nq   <= n[DW-1:0];
      d    <= den4;
      kind <= kind4;
      alt  <= alt4;
      pos  <= pos4;
      neg  <= neg4;
    end
  end

endmodule

// ===== rtl/pqd_div_cell.sv =====
`timescale 1ns / 1ps

module pqd_div_cell #(
  parameter int DW = 57
) (
  input  logic                clk,
  input  logic                en,
  input  logic [DW-1:0]       r_in,
  input  logic [DW-1:0]       nq_in,
  input  logic [DW-1:0]       d_in,
  input  pqd_pkg::edge_kind_t kind_in,
  input  logic [DW-1:0]       alt_in,
  output logic [DW-1:0]       r_out,
  output logic [DW-1:0]       nq_out,
  output logic [DW-1:0]       d_out,
  output pqd_pkg::edge_kind_t kind_out,
  output logic [DW-1:0]       alt_out
);

  logic [DW:0] t, diff;
  logic        ge;

  assign t    = {r_in, nq_in[DW-1]};
  assign ge   = t >= {1'b0, d_in};
  assign diff = t - {1'b0, d_in};

  always_ff @(posedge clk) begin
    if (en) begin
      r_out    <= ge ? diff[DW-1:0] : t[DW-1:0];
      nq_out   <= {nq_in[DW-2:0], ge};
      d_out    <= d_in;
      kind_out <= kind_in;
      alt_out  <= alt_in;
    end
  end

endmodule

// ===== rtl/pqd_sqrt_cell.sv =====
`timescale 1ns / 1ps

module pqd_sqrt_cell #(
  parameter int OW = 29
) (
  input  logic              clk,
  input  logic              en,
  input  logic [OW+1:0]     rem_in,
  input  logic [OW-1:0]     root_in,
  input  logic [2*OW-1:0]   rest_in,
  output logic [OW+1:0]     rem_out,
  output logic [OW-1:0]     root_out,
  output logic [2*OW-1:0]   rest_out
);

  logic [OW+1:0] cand, trial;
  logic          ge;

  assign cand  = {rem_in[OW-1:0], rest_in[2*OW-1:2*OW-2]};
  assign trial = {root_in, 2'b01};
  assign ge    = cand >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= ge ? cand - trial : cand;
      root_out <= {root_in[OW-2:0], ge};
      rest_out <= {rest_in[2*OW-3:0], 2'b00};
    end
  end

endmodule

// ===== rtl/point_to_quad_distance_core.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
// in        in         in_valid / in_ready    point_x, point_y
// out       out        out_valid / out_ready  distance
//
// One point per cycle while the pipeline advances. The pipeline is five front stages,
// one divider cell per quotient bit (2*COORD_WIDTH + 1), two min stages,
// one root cell per result bit (COORD_WIDTH + 1) and the output register.
// rst clears the corners to zero and empties the pipeline.
// The whole pipeline holds while the output register is full and not taken.
// cfg_ready is always high.

module point_to_quad_distance_core #(
  parameter int COORD_WIDTH = 28
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pqd_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [COORD_WIDTH-1:0]                 cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [COORD_WIDTH-1:0]          point_x,
  input  logic signed [COORD_WIDTH-1:0]          point_y,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [COORD_WIDTH:0]                   distance
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = 2 * W + 1;
  localparam int OW = W + 1;
  localparam int FL = 5;

  logic signed [W-1:0] cx [4];
  logic signed [W-1:0] cy [4];
  logic                adv;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        cx[i] <= '0;
        cy[i] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (pqd_pkg::cfg_reg_t'(cfg_index))
        pqd_pkg::REG_C0X: cx[0] <= cfg_data;
        pqd_pkg::REG_C0Y: cy[0] <= cfg_data;
        pqd_pkg::REG_C1X: cx[1] <= cfg_data;
        pqd_pkg::REG_C1Y: cy[1] <= cfg_data;
        pqd_pkg::REG_C2X: cx[2] <= cfg_data;
        pqd_pkg::REG_C2Y: cy[2] <= cfg_data;
        pqd_pkg::REG_C3X: cx[3] <= cfg_data;
        pqd_pkg::REG_C3Y: cy[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [DW-1:0]       dr    [4][DW+1];
  logic [DW-1:0]       dnq   [4][DW+1];
  logic [DW-1:0]       dd    [4][DW+1];
  pqd_pkg::edge_kind_t dkind [4][DW+1];
  logic [DW-1:0]       dalt  [4][DW+1];
  logic [3:0]          f_pos, f_neg;

  for (genvar e = 0; e < 4; e++) begin : g_edge
    pqd_edge_front #(.W(W)) u_front (
      .clk  (clk),
      .en   (adv),
      .ax   (cx[e]),
      .ay   (cy[e]),
      .bx   (cx[(e + 1) % 4]),
      .by   (cy[(e + 1) % 4]),
      .px   (point_x),
      .py   (point_y),
      .r    (dr[e][0]),
      .nq   (dnq[e][0]),
      .d    (dd[e][0]),
      .kind (dkind[e][0]),
      .alt  (dalt[e][0]),
      .pos  (f_pos[e]),
      .neg  (f_neg[e])
    );

    for (genvar k = 0; k < DW; k++) begin : g_div
      pqd_div_cell #(.DW(DW)) u_cell (
        .clk      (clk),
        .en       (adv),
        .r_in     (dr[e][k]),
        .nq_in    (dnq[e][k]),
        .d_in     (dd[e][k]),
        .kind_in  (dkind[e][k]),
        .alt_in   (dalt[e][k]),
        .r_out    (dr[e][k+1]),
        .nq_out   (dnq[e][k+1]),
        .d_out    (dd[e][k+1]),
        .kind_out (dkind[e][k+1]),
        .alt_out  (dalt[e][k+1])
      );
    end
  end

  logic [FL-1:0] fv;
  logic [DW-1:0] dv, dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
      dv <= '0;
    end else if (adv) begin
      fv <= {fv[FL-2:0], in_valid};
      dv <= {dv[DW-2:0], fv[FL-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout <= {dout[DW-2:0], (|f_pos) && (|f_neg)};
    end
  end

  logic [DW-1:0] ev   [4];
  logic [3:0]    ehave;
  logic [DW-1:0] m1_val [2];
  logic [1:0]    m1_have;
  logic          m1v, m1o, m2v, m2o;
  logic [DW-1:0] m2_val;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ev[i]    = (dkind[i][DW] == pqd_pkg::EDGE_PERP) ? dnq[i][DW] : dalt[i][DW];
      ehave[i] = dkind[i][DW] != pqd_pkg::EDGE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 2; j++) begin
        if (ehave[2*j] && (!ehave[2*j+1] || ev[2*j] <= ev[2*j+1])) begin
          m1_val[j] <= ev[2*j];
        end else begin
          m1_val[j] <= ev[2*j+1];
        end
        m1_have[j] <= ehave[2*j] || ehave[2*j+1];
      end
      m1o <= dout[DW-1];
      if (m1_have[0] && (!m1_have[1] || m1_val[0] <= m1_val[1])) begin
        m2_val <= m1_val[0];
      end else if (m1_have[1]) begin
        m2_val <= m1_val[1];
      end else begin
        m2_val <= '0;
      end
      m2o <= m1o;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1v <= 1'b0;
      m2v <= 1'b0;
    end else if (adv) begin
      m1v <= dv[DW-1];
      m2v <= m1v;
    end
  end

  logic [OW+1:0]   sq_rem  [OW+1];
  logic [OW-1:0]   sq_root [OW+1];
  logic [2*OW-1:0] sq_rest [OW+1];
  logic [OW-1:0]   sv, so;

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rest[0] = {1'b0, m2_val};

  for (genvar k = 0; k < OW; k++) begin : g_sqrt
    pqd_sqrt_cell #(.OW(OW)) u_cell (
      .clk      (clk),
      .en       (adv),
      .rem_in   (sq_rem[k]),
      .root_in  (sq_root[k]),
      .rest_in  (sq_rest[k]),
      .rem_out  (sq_rem[k+1]),
      .root_out (sq_root[k+1]),
      .rest_out (sq_rest[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv        <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      sv        <= {sv[OW-2:0], m2v};
      out_valid <= sv[OW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      so       <= {so[OW-2:0], m2o};
      distance <= so[OW-1] ? sq_root[OW] : '0;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_dist_outside: assert property (@(posedge clk) disable iff (rst)
    ($past(adv) && out_valid && distance != '0) |-> $past(so[OW-1]))
    else $error("nonzero distance for a point not outside");

  for (genvar e = 0; e < 4; e++) begin : g_chk
    a_quot_bound: assert property (@(posedge clk) disable iff (rst)
      (dv[DW-1] && dkind[e][DW] == pqd_pkg::EDGE_PERP) |-> (dnq[e][DW] <= dalt[e][DW]))
      else $error("segment distance above end corner distance");

    a_rem_bound: assert property (@(posedge clk) disable iff (rst)
      (dv[DW-1] && dkind[e][DW] == pqd_pkg::EDGE_PERP) |-> (dr[e][DW] < dd[e][DW]))
      else $error("divider remainder not below divisor");
  end

endmodule

// ===== tb/point_to_quad_distance_core_tb.sv =====
`timescale 1ns / 1ps

class quad_distance_board;
  logic signed [27:0] corner [8];
  logic [28:0] expected_distance [$];
  int mismatches;

  function new();
    foreach (corner[i]) corner[i] = '0;
    mismatches = 0;
  endfunction

  function void set_corner(int idx, logic signed [27:0] val);
    corner[idx] = val;
  endfunction

  function longint unsigned root_floor(longint unsigned n);
    longint unsigned r, c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function longint unsigned perp_floor(longint unsigned crm, longint unsigned den);
    logic [127:0] lim;
    longint unsigned r, c, sq;
    lim = 128'(crm) * 128'(crm);
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      sq = c * c;
      if (128'(sq) * 128'(den) <= lim) r = c;
    end
    return r;
  endfunction

  function logic [28:0] quad_distance(logic signed [27:0] px_in, logic signed [27:0] py_in);
    longint px, py, ax, ay, bx, by, dx, dy, ex, ey, cr, dot, den, fx, fy;
    bit pos, neg, have;
    longint unsigned best, d;
    int j;
    px = px_in;
    py = py_in;
    pos = 0;
    neg = 0;
    have = 0;
    best = 0;
    for (int i = 0; i < 4; i++) begin
      j = (i + 1) % 4;
      ax = corner[2*i];
      ay = corner[2*i+1];
      bx = corner[2*j];
      by = corner[2*j+1];
      dx = bx - ax;
      dy = by - ay;
      ex = px - ax;
      ey = py - ay;
      cr = dx * ey - dy * ex;
      dot = ex * dx + ey * dy;
      den = dx * dx + dy * dy;
      if (cr > 0) pos = 1;
      else if (cr < 0) neg = 1;
      if (den == 0) continue;
      if (dot <= 0) begin
        d = root_floor(ex * ex + ey * ey);
      end else if (dot >= den) begin
        fx = px - bx;
        fy = py - by;
        d = root_floor(fx * fx + fy * fy);
      end else begin
        d = perp_floor(cr < 0 ? -cr : cr, den);
      end
      if (!have || d < best) begin
        best = d;
        have = 1;
      end
    end
    return (pos && neg) ? best[28:0] : 29'd0;
  endfunction

  function void note_request(logic signed [27:0] px, logic signed [27:0] py);
    expected_distance.push_back(quad_distance(px, py));
  endfunction

  function void check_distance(logic [28:0] actual);
    logic [28:0] exp_d;
    if (expected_distance.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result distance=%0d", actual);
      return;
    end
    exp_d = expected_distance.pop_front();
    if (exp_d !== actual) begin
      mismatches++;
      if (mismatches <= 10)
        $display("distance mismatch: expected %0d actual %0d", exp_d, actual);
    end
  endfunction

  function int pending();
    return expected_distance.size();
  endfunction
endclass

module point_to_quad_distance_core_tb;

  localparam int W = 28;
  localparam longint CYCLE_LIMIT = 1000000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [pqd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [W-1:0] point_x = '0;
  logic signed [W-1:0] point_y = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [W:0] distance;

  quad_distance_board board = new();
  bit quiet = 0;
  longint cycles = 0;

  point_to_quad_distance_core #(.COORD_WIDTH(W)) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .point_x(point_x), .point_y(point_y),
    .out_valid(out_valid), .out_ready(out_ready), .distance(distance)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_distance(distance);
  end

  initial begin
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic write_reg(pqd_pkg::cfg_reg_t r, logic signed [W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= r;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_corner(int'(r), val);
  endtask

  task automatic load_quad(logic signed [W-1:0] c [8]);
    for (int i = 0; i < 8; i++) write_reg(pqd_pkg::cfg_reg_t'(i), c[i]);
    cfg_valid <= 0;
  endtask

  task automatic send_point(logic signed [W-1:0] x, logic signed [W-1:0] y);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1;
    point_x <= x;
    point_y <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(x, y);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending() != 0) @(posedge clk);
    repeat (110) @(posedge clk);
  endtask

  function automatic logic signed [W-1:0] near(logic signed [W-1:0] base, int span);
    longint v;
    v = longint'(base) + $signed($urandom_range(0, 2 * span)) - span;
    if (v > 134217727) v = 134217727;
    if (v < -134217728) v = -134217728;
    return v[W-1:0];
  endfunction

  task automatic random_points(int n);
    logic signed [W-1:0] x, y;
    int k;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: begin
          x = W'($urandom);
          y = W'($urandom);
        end
        1: begin
          k = $urandom_range(0, 3);
          x = near(board.corner[2*k], 64);
          y = near(board.corner[2*k+1], 64);
        end
        default: begin
          k = $urandom_range(0, 3);
          x = near(board.corner[2*k], 1 << $urandom_range(4, 26));
          y = near(board.corner[2*k+1], 1 << $urandom_range(4, 26));
        end
      endcase
      send_point(x, y);
    end
  endtask

  initial begin
    logic signed [W-1:0] q [8];
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // all corners at zero: every edge degenerate
    send_point(28'sd5, -28'sd7);
    send_point(28'h7FFFFFF, 28'h8000000);
    drain();

    q = '{-28'sd160, -28'sd160, 28'sd160, -28'sd160, 28'sd160, 28'sd160, -28'sd160, 28'sd160};
    load_quad(q);
    send_point(28'sd0, 28'sd0);
    send_point(28'sd160, 28'sd0);
    send_point(28'sd160, 28'sd160);
    send_point(28'sd200, 28'sd0);
    send_point(28'sd0, -28'sd300);
    send_point(28'sd500, 28'sd500);
    send_point(-28'sd161, -28'sd170);
    send_point(28'h7FFFFFF, 28'h7FFFFFF);
    send_point(28'h8000000, 28'h8000000);
    send_point(28'h8000000, 28'h7FFFFFF);
    drain();

    // two corners coincide: one degenerate edge
    q = '{28'sd0, 28'sd0, 28'sd0, 28'sd0, 28'sd1000, 28'sd0, 28'sd0, 28'sd1000};
    load_quad(q);
    send_point(28'sd100, 28'sd100);
    send_point(-28'sd50, 28'sd500);
    send_point(28'sd2000, 28'sd2000);
    send_point(28'sd700, 28'sd700);
    drain();

    // extreme corners
    q = '{28'h8000000, 28'h8000000, 28'h7FFFFFF, 28'h8000000,
          28'h7FFFFFF, 28'h7FFFFFF, 28'h8000000, 28'h7FFFFFF};
    load_quad(q);
    send_point(28'sd0, 28'sd0);
    send_point(28'h7FFFFFF, 28'sd0);
    send_point(28'h8000000, 28'sd12345);
    send_point(28'sd1, 28'h7FFFFFF);
    random_points(150);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 8; i++) begin
        if (ph % 2 == 0) q[i] = W'($urandom);
        else q[i] = near(28'sd0, 1 << $urandom_range(3, 20));
      end
      load_quad(q);
      if (ph == 5) quiet = 1;
      random_points(230);
      drain();
    end

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/pqd_pkg.sv
rtl/pqd_edge_front.sv
rtl/pqd_div_cell.sv
rtl/pqd_sqrt_cell.sv
rtl/point_to_quad_distance_core.sv
tb/point_to_quad_distance_core_tb.sv
